// ----- sv/tlcd_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tlcd_pkg
// Shared types and constants of the text terminal for a page-addressed LCD.
// ----------------------------------------------------------------------------
package tlcd_pkg;

   // defaults of the top-level parameters
   localparam int DEF_TEXT_LINES     = 8;
   localparam int DEF_CHARS_PER_LINE = 16;

   // field widths
   localparam int OP_W     = 2;
   localparam int CODE_W   = 8;
   localparam int COORD_W  = 8;
   localparam int FONT_AW  = 11;
   localparam int BYTE_W   = 8;
   localparam int LINE_W   = 4;
   localparam int CHAR_W   = 5;
   localparam int COLPIX_W = 7;
   localparam int STEP_W   = 4;

   localparam int FONT_DEPTH  = 1280;
   localparam int QUEUE_DEPTH = 4;

   // operation codes
   localparam logic [OP_W-1:0] OP_PUT  = 2'd0;
   localparam logic [OP_W-1:0] OP_GOTO = 2'd1;
   localparam logic [OP_W-1:0] OP_LOAD = 2'd2;

   // special characters
   localparam logic [CODE_W-1:0] CODE_NEWLINE = 8'd13;
   localparam logic [CODE_W-1:0] CODE_RETURN  = 8'd10;

   // controller commands
   localparam logic [BYTE_W-1:0] CMD_PAGE   = 8'hb0;
   localparam logic [BYTE_W-1:0] CMD_COL_HI = 8'h10;
   localparam logic [BYTE_W-1:0] CMD_COL_LO = 8'h00;
   localparam logic [BYTE_W-1:0] BLANK_COL  = 8'h00;

   localparam int CELL_WIDTH = 6;
   localparam int GLYPH_COLS = 5;

   // back-end sequence steps
   localparam logic [STEP_W-1:0] STEP_PAGE        = 4'd0;
   localparam logic [STEP_W-1:0] STEP_COL_HI      = 4'd1;
   localparam logic [STEP_W-1:0] STEP_COL_LO      = 4'd2;
   localparam logic [STEP_W-1:0] STEP_GLYPH       = 4'd3;
   localparam logic [STEP_W-1:0] STEP_GLYPH_LAST  = 4'd7;
   localparam logic [STEP_W-1:0] STEP_BLANK       = 4'd8;

   typedef enum logic [1:0] {
      KIND_HOME,
      KIND_GLYPH,
      KIND_WRAP,
      KIND_LOAD
   } tlcd_kind_type;

   typedef enum logic {
      ST_IDLE,
      ST_RUN
   } tlcd_state_type;

   // one classified job from the front end
   typedef struct packed {
      tlcd_kind_type         kind;
      logic [LINE_W-1:0]     page;
      logic [COLPIX_W-1:0]   colpix;
      logic [FONT_AW-1:0]    addr;
      logic [BYTE_W-1:0]     data;
   } tlcd_entry_type;

   // one output byte on its way to the result register
   typedef struct packed {
      logic                is_data;
      logic [BYTE_W-1:0]   out_byte;
      logic                use_ram;
      logic                last;
   } tlcd_beat_type;

endpackage
`default_nettype wire

// ----- sv/tlcd_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tlcd_ram
// Generic single-write, single-read RAM with registered, enabled read.
// ----------------------------------------------------------------------------
module tlcd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1280
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule
`default_nettype wire

// ----- sv/tlcd_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tlcd_queue
// Short job queue between the front end and the back-end sequencer.
// ----------------------------------------------------------------------------
module tlcd_queue (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     push_valid,
   input  wire tlcd_pkg::tlcd_entry_type push_data,
   output logic                          full,
   input  wire logic                     pop,
   output logic                          pop_valid,
   output tlcd_pkg::tlcd_entry_type      pop_data
);
   import tlcd_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = PTR_W + 1;

   tlcd_entry_type     slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push;
   logic               do_pop;

   assign full      = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_data  = slot_ff[rd_ptr_ff];
   assign do_push   = push_valid && !full;
   assign do_pop    = pop && pop_valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

// ----- sv/tlcd_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tlcd_front
// Accepts operations, keeps the line and character cursors and turns each
// operation into at most one queued job for the back end.
// ----------------------------------------------------------------------------
module tlcd_front #(
   parameter int TEXT_LINES     = tlcd_pkg::DEF_TEXT_LINES,
   parameter int CHARS_PER_LINE = tlcd_pkg::DEF_CHARS_PER_LINE
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [tlcd_pkg::OP_W-1:0]     req_op,
   input  wire logic [tlcd_pkg::CODE_W-1:0]   req_char_code,
   input  wire logic [tlcd_pkg::COORD_W-1:0]  req_goto_col,
   input  wire logic [tlcd_pkg::COORD_W-1:0]  req_goto_row,
   input  wire logic [tlcd_pkg::FONT_AW-1:0]  req_font_addr,
   input  wire logic [tlcd_pkg::BYTE_W-1:0]   req_font_byte,
   output logic                               push_valid,
   output tlcd_pkg::tlcd_entry_type           push_data,
   input  wire logic                          queue_full
);
   import tlcd_pkg::*;

   logic [LINE_W-1:0]   line_cursor_ff, line_cursor_in;
   logic [CHAR_W-1:0]   char_cursor_ff, char_cursor_in;
   logic                accept;
   logic [LINE_W-1:0]   line_next;
   logic [CHAR_W-1:0]   col_clamped;
   logic [LINE_W-1:0]   row_clamped;
   logic [FONT_AW-1:0]  glyph_base;

   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready;

   always_comb begin
      // line advance with wrap
      if (({1'b0, line_cursor_ff} + 5'd1) >= 5'(TEXT_LINES)) begin
         line_next = '0;
      end else begin
         line_next = line_cursor_ff + LINE_W'(1);
      end
      col_clamped = (req_goto_col > COORD_W'(CHARS_PER_LINE - 1)) ? '0
                                                                   : CHAR_W'(req_goto_col);
      row_clamped = (req_goto_row > COORD_W'(TEXT_LINES - 1)) ? '0
                                                              : LINE_W'(req_goto_row);
      // code * 5
      glyph_base = {1'b0, req_char_code, 2'b00} + {3'b000, req_char_code};
   end

   always_comb begin
      line_cursor_in   = line_cursor_ff;
      char_cursor_in   = char_cursor_ff;
      push_valid       = 1'b0;
      push_data.kind   = KIND_HOME;
      push_data.page   = line_cursor_ff;
      push_data.colpix = '0;
      push_data.addr   = glyph_base;
      push_data.data   = req_font_byte;
      if (accept) begin
         unique case (req_op)
            OP_PUT: begin
               push_valid = 1'b1;
               if (req_char_code == CODE_NEWLINE) begin
                  line_cursor_in = line_next;
                  char_cursor_in = '0;
                  push_data.page = line_next;
               end else if (req_char_code == CODE_RETURN) begin
                  char_cursor_in = '0;
               end else if (char_cursor_ff < CHAR_W'(CHARS_PER_LINE)) begin
                  char_cursor_in = char_cursor_ff + CHAR_W'(1);
                  push_data.kind = KIND_GLYPH;
               end else begin
                  line_cursor_in = line_next;
                  char_cursor_in = CHAR_W'(1);
                  push_data.kind = KIND_WRAP;
                  push_data.page = line_next;
               end
            end
            OP_GOTO: begin
               push_valid       = 1'b1;
               line_cursor_in   = row_clamped;
               char_cursor_in   = col_clamped;
               push_data.page   = row_clamped;
               push_data.colpix = COLPIX_W'(col_clamped) * COLPIX_W'(CELL_WIDTH);
            end
            OP_LOAD: begin
               push_valid     = (req_font_addr < FONT_AW'(FONT_DEPTH));
               push_data.kind = KIND_LOAD;
               push_data.addr = req_font_addr;
            end
            default: begin
               push_valid = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_cursor_ff <= '0;
         char_cursor_ff <= '0;
      end else begin
         line_cursor_ff <= line_cursor_in;
         char_cursor_ff <= char_cursor_in;
      end
   end

   a_char_in_range: assert property (@(posedge clock) disable iff (reset)
      char_cursor_ff <= CHAR_W'(CHARS_PER_LINE))
      else $error("char cursor past end of line");

   a_line_in_range: assert property (@(posedge clock) disable iff (reset)
      {1'b0, line_cursor_ff} < 5'(TEXT_LINES))
      else $error("line cursor past last line");

   a_bad_load_dropped: assert property (@(posedge clock) disable iff (reset)
      (accept && req_op == OP_LOAD && req_font_addr >= FONT_AW'(FONT_DEPTH))
      |-> !push_valid)
      else $error("out-of-range font load queued");

endmodule
`default_nettype wire

// ----- sv/tlcd_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tlcd_back
// Sequencer that expands queued jobs into command and data bytes, reads the
// font memory, writes the font loads into it and holds the result register.
// ----------------------------------------------------------------------------
module tlcd_back (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          job_valid,
   input  wire tlcd_pkg::tlcd_entry_type      job_data,
   output logic                               job_pop,
   output logic                               ram_wr_en,
   output logic [tlcd_pkg::FONT_AW-1:0]       ram_wr_addr,
   output logic [tlcd_pkg::BYTE_W-1:0]        ram_wr_data,
   output logic                               ram_rd_en,
   output logic [tlcd_pkg::FONT_AW-1:0]       ram_rd_addr,
   input  wire logic [tlcd_pkg::BYTE_W-1:0]   ram_rd_data,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic                               rsp_is_data,
   output logic [tlcd_pkg::BYTE_W-1:0]        rsp_out_byte,
   output logic                               rsp_last
);
   import tlcd_pkg::*;

   tlcd_state_type      state_ff, state_in;
   tlcd_entry_type      cur_ff;
   logic [STEP_W-1:0]   step_ff, step_in;
   tlcd_beat_type       s1_ff, beat;
   logic                s1_valid_ff, s1_valid_in;
   logic                rsp_valid_ff;
   logic                rsp_is_data_ff;
   logic [BYTE_W-1:0]   rsp_byte_ff;
   logic                rsp_last_ff;
   logic                out_load;
   logic                s1_free;
   logic                issue;
   logic                at_end;
   logic [STEP_W-1:0]   end_step;
   logic [STEP_W-1:0]   start_step;
   logic                start_job;

   assign out_load  = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign s1_free   = !s1_valid_ff || out_load;
   assign issue     = (state_ff == ST_RUN) && s1_free;
   assign end_step  = (cur_ff.kind == KIND_HOME) ? STEP_COL_LO : STEP_BLANK;
   assign at_end    = (step_ff == end_step);
   assign start_step = (job_data.kind == KIND_GLYPH) ? STEP_GLYPH : STEP_PAGE;
   assign job_pop   = job_valid && ((state_ff == ST_IDLE) || (issue && at_end));
   assign start_job = job_pop && (job_data.kind != KIND_LOAD);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start_job) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (issue && at_end) begin
               state_in = start_job ? ST_RUN : ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // sequencer outputs
   always_comb begin
      ram_wr_en     = job_pop && (job_data.kind == KIND_LOAD);
      ram_wr_addr   = job_data.addr;
      ram_wr_data   = job_data.data;
      ram_rd_addr   = cur_ff.addr + FONT_AW'(step_ff - STEP_GLYPH);
      ram_rd_en     = 1'b0;
      beat.is_data  = 1'b1;
      beat.out_byte = BLANK_COL;
      beat.use_ram  = 1'b0;
      beat.last     = at_end;
      unique case (step_ff) inside
         STEP_PAGE: begin
            beat.is_data  = 1'b0;
            beat.out_byte = CMD_PAGE + BYTE_W'(cur_ff.page);
         end
         STEP_COL_HI: begin
            beat.is_data  = 1'b0;
            beat.out_byte = CMD_COL_HI + BYTE_W'(cur_ff.colpix[COLPIX_W-1:4]);
         end
         STEP_COL_LO: begin
            beat.is_data  = 1'b0;
            beat.out_byte = CMD_COL_LO + BYTE_W'(cur_ff.colpix[3:0]);
         end
         [STEP_GLYPH:STEP_GLYPH_LAST]: begin
            beat.use_ram = 1'b1;
            ram_rd_en    = issue;
         end
         default: begin
            beat.out_byte = BLANK_COL;
         end
      endcase
   end

   always_comb begin
      step_in = step_ff;
      if (start_job) begin
         step_in = start_step;
      end else if (issue) begin
         step_in = step_ff + STEP_W'(1);
      end
      if (issue) begin
         s1_valid_in = 1'b1;
      end else if (out_load) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         s1_valid_ff <= s1_valid_in;
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
      if (start_job) begin
         cur_ff <= job_data;
      end
      if (issue) begin
         s1_ff <= beat;
      end
      if (out_load) begin
         rsp_is_data_ff <= s1_ff.is_data;
         rsp_byte_ff    <= s1_ff.use_ram ? ram_rd_data : s1_ff.out_byte;
         rsp_last_ff    <= s1_ff.last;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_is_data  = rsp_is_data_ff;
   assign rsp_out_byte = rsp_byte_ff;
   assign rsp_last     = rsp_last_ff;

   a_step_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN) |-> (step_ff <= STEP_BLANK))
      else $error("sequencer step out of range");

   a_job_starts: assert property (@(posedge clock) disable iff (reset)
      start_job |=> (state_ff == ST_RUN))
      else $error("popped job did not start");

   a_font_beat_is_data: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s1_ff.use_ram) |-> s1_ff.is_data)
      else $error("font byte marked as command");

endmodule
`default_nettype wire

// ----- sv/text_cursor_to_lcd_stream.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// text_cursor_to_lcd_stream
// Character terminal for a page-addressed monochrome LCD with a 5x8 font.
// ----------------------------------------------------------------------------
// Each request is one operation (put character, goto, load font byte); the
// block answers with the command and data bytes for the LCD controller, one
// byte per transfer, with last set on the final byte of an operation. The
// front end takes one request per cycle while its 4-entry job queue has
// room; the back-end sequencer emits one byte per cycle while results are
// taken: 6 for a printed character, 9 for one that wraps the line, 3 each
// for newline, carriage return and goto, none for a font load. That
// sequencer, which reads the font memory through its single read port,
// sets the sustained rate. Results leave through a register, so the next
// byte is prepared while one waits. The font memory is not cleared;
// glyphs must be loaded before they print.
// ----------------------------------------------------------------------------
module text_cursor_to_lcd_stream #(
   parameter int TEXT_LINES     = tlcd_pkg::DEF_TEXT_LINES,
   parameter int CHARS_PER_LINE = tlcd_pkg::DEF_CHARS_PER_LINE
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [tlcd_pkg::OP_W-1:0]     req_op,
   input  wire logic [tlcd_pkg::CODE_W-1:0]   req_char_code,
   input  wire logic [tlcd_pkg::COORD_W-1:0]  req_goto_col,
   input  wire logic [tlcd_pkg::COORD_W-1:0]  req_goto_row,
   input  wire logic [tlcd_pkg::FONT_AW-1:0]  req_font_addr,
   input  wire logic [tlcd_pkg::BYTE_W-1:0]   req_font_byte,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic                               rsp_is_data,
   output logic [tlcd_pkg::BYTE_W-1:0]        rsp_out_byte,
   output logic                               rsp_last
);
   import tlcd_pkg::*;

   logic                push_valid;
   tlcd_entry_type      push_data;
   logic                queue_full;
   logic                job_pop;
   logic                job_valid;
   tlcd_entry_type      job_data;
   logic                ram_wr_en;
   logic [FONT_AW-1:0]  ram_wr_addr;
   logic [BYTE_W-1:0]   ram_wr_data;
   logic                ram_rd_en;
   logic [FONT_AW-1:0]  ram_rd_addr;
   logic [BYTE_W-1:0]   ram_rd_data;

   tlcd_front #(
      .TEXT_LINES     (TEXT_LINES),
      .CHARS_PER_LINE (CHARS_PER_LINE)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_op        (req_op),
      .req_char_code (req_char_code),
      .req_goto_col  (req_goto_col),
      .req_goto_row  (req_goto_row),
      .req_font_addr (req_font_addr),
      .req_font_byte (req_font_byte),
      .push_valid    (push_valid),
      .push_data     (push_data),
      .queue_full    (queue_full)
   );

   tlcd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .full       (queue_full),
      .pop        (job_pop),
      .pop_valid  (job_valid),
      .pop_data   (job_data)
   );

   tlcd_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (FONT_DEPTH)
   ) u_font (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   tlcd_back u_back (
      .clock        (clock),
      .reset        (reset),
      .job_valid    (job_valid),
      .job_data     (job_data),
      .job_pop      (job_pop),
      .ram_wr_en    (ram_wr_en),
      .ram_wr_addr  (ram_wr_addr),
      .ram_wr_data  (ram_wr_data),
      .ram_rd_en    (ram_rd_en),
      .ram_rd_addr  (ram_rd_addr),
      .ram_rd_data  (ram_rd_data),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_is_data  (rsp_is_data),
      .rsp_out_byte (rsp_out_byte),
      .rsp_last     (rsp_last)
   );

endmodule
`default_nettype wire

// ----- tb/sv/tb_text_cursor_to_lcd_stream.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_text_cursor_to_lcd_stream
// Self-checking regression for the LCD text terminal.
// ----------------------------------------------------------------------------
// Requests go in one transfer at a time and a model of the terminal
// (cursors plus font store) predicts the command and data bytes for each
// one. A monitor compares every result transfer with the oldest predicted
// byte. Directed tests cover font loads, ignored requests, goto clamping,
// line wrap and page wrap. A random phase mixes glyph loads, prints, cursor
// moves and noise. A back-to-back phase follows. Both sides stall at random
// outside the back-to-back phase. Only glyphs that are fully loaded are
// ever printed.
// ----------------------------------------------------------------------------
module tb_text_cursor_to_lcd_stream;
   import tlcd_pkg::*;

   localparam int TEXT_LINES     = DEF_TEXT_LINES;
   localparam int CHARS_PER_LINE = DEF_CHARS_PER_LINE;
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
   localparam int MAX_BURST = 9;

   typedef struct packed {
      logic              is_data;
      logic [BYTE_W-1:0] out_byte;
      logic              last;
   } lcd_byte_type;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_ready;
   logic [OP_W-1:0]     req_op;
   logic [CODE_W-1:0]   req_char_code;
   logic [COORD_W-1:0]  req_goto_col;
   logic [COORD_W-1:0]  req_goto_row;
   logic [FONT_AW-1:0]  req_font_addr;
   logic [BYTE_W-1:0]   req_font_byte;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic                rsp_is_data;
   logic [BYTE_W-1:0]   rsp_out_byte;
   logic                rsp_last;

   // terminal model state
   logic [LINE_W-1:0]   line_cur;
   logic [CHAR_W-1:0]   char_cur;
   logic [BYTE_W-1:0]   font_mem [FONT_DEPTH];
   bit                  font_written [FONT_DEPTH];
   bit                  glyph_loaded [256];
   int                  printable_codes [$];

   lcd_byte_type        burst [MAX_BURST];
   int                  burst_len;
   lcd_byte_type        expected_bytes [$];

   int                  fail_count = 0;
   int                  items_sent = 0;
   bit                  steady = 1'b0;

   text_cursor_to_lcd_stream #(
      .TEXT_LINES     (TEXT_LINES),
      .CHARS_PER_LINE (CHARS_PER_LINE)
   ) dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_op        (req_op),
      .req_char_code (req_char_code),
      .req_goto_col  (req_goto_col),
      .req_goto_row  (req_goto_row),
      .req_font_addr (req_font_addr),
      .req_font_byte (req_font_byte),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_is_data   (rsp_is_data),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_last      (rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #200000;
      $display("text_cursor_to_lcd_stream regression: fail");
      $finish;
   end

   // ---------------------------------------------------------------- model

   function automatic void add_byte(input logic is_data, input logic [BYTE_W-1:0] b);
      burst[burst_len] = '{is_data: is_data, out_byte: b, last: 1'b0};
      burst_len++;
   endfunction

   function automatic void home_cmds();
      add_byte(1'b0, CMD_PAGE + BYTE_W'(line_cur));
      add_byte(1'b0, CMD_COL_HI);
      add_byte(1'b0, CMD_COL_LO);
   endfunction

   function automatic void next_line();
      if (int'(line_cur) >= TEXT_LINES - 1) line_cur = '0;
      else line_cur = line_cur + 1'b1;
      char_cur = '0;
      home_cmds();
   endfunction

   function automatic void glyph_bytes(input logic [CODE_W-1:0] code);
      for (int i = 0; i < GLYPH_COLS; i++)
         add_byte(1'b1, font_mem[int'(code) * GLYPH_COLS + i]);
      add_byte(1'b1, BLANK_COL);
   endfunction

   // a code other than newline or return is printable once its glyph columns are all written
   function automatic void note_glyph(input int code);
      bit full = 1'b1;
      for (int i = 0; i < GLYPH_COLS; i++)
         if (!font_written[code * GLYPH_COLS + i]) full = 1'b0;
      if (full && !glyph_loaded[code] && code != int'(CODE_NEWLINE)
          && code != int'(CODE_RETURN)) begin
         glyph_loaded[code] = 1'b1;
         printable_codes.push_back(code);
      end
   endfunction

   function automatic void predict_bytes(input logic [OP_W-1:0] op,
                                         input logic [CODE_W-1:0] code,
                                         input logic [COORD_W-1:0] col,
                                         input logic [COORD_W-1:0] row,
                                         input logic [FONT_AW-1:0] addr,
                                         input logic [BYTE_W-1:0] fbyte);
      logic [COORD_W-1:0] c;
      logic [COORD_W-1:0] r;
      int k;
      burst_len = 0;
      case (op)
         OP_PUT: begin
            if (code == CODE_NEWLINE) begin
               next_line();
            end else if (code == CODE_RETURN) begin
               char_cur = '0;
               home_cmds();
            end else if (int'(char_cur) < CHARS_PER_LINE) begin
               char_cur = char_cur + 1'b1;
               glyph_bytes(code);
            end else begin
               next_line();
               glyph_bytes(code);
               char_cur = CHAR_W'(1);
            end
            items_sent++;
         end
         OP_GOTO: begin
            c = (int'(col) > CHARS_PER_LINE - 1) ? '0 : col;
            r = (int'(row) > TEXT_LINES - 1) ? '0 : row;
            char_cur = CHAR_W'(c);
            line_cur = LINE_W'(r);
            k = int'(c) * CELL_WIDTH;
            add_byte(1'b0, CMD_PAGE + r);
            add_byte(1'b0, CMD_COL_HI + BYTE_W'(k >> 4));
            add_byte(1'b0, CMD_COL_LO + BYTE_W'(k & 15));
            items_sent++;
         end
         OP_LOAD: begin
            if (int'(addr) < FONT_DEPTH) begin
               font_mem[addr] = fbyte;
               font_written[addr] = 1'b1;
               note_glyph(int'(addr) / GLYPH_COLS);
               items_sent++;
            end
         end
         default: ;
      endcase
      for (int i = 0; i < burst_len; i++) begin
         burst[i].last = (i == burst_len - 1);
         expected_bytes.push_back(burst[i]);
      end
   endfunction

   // ------------------------------------------------------------- drivers

   task automatic send_item(input logic [OP_W-1:0] op, input logic [CODE_W-1:0] code,
                            input logic [COORD_W-1:0] col, input logic [COORD_W-1:0] row,
                            input logic [FONT_AW-1:0] addr, input logic [BYTE_W-1:0] fbyte);
      while (!steady && $urandom_range(99) < 35) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_op        <= op;
      req_char_code <= code;
      req_goto_col  <= col;
      req_goto_row  <= row;
      req_font_addr <= addr;
      req_font_byte <= fbyte;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_bytes(op, code, col, row, addr, fbyte);
      @(negedge clock);
   endtask

   task automatic put_char(input logic [CODE_W-1:0] code);
      send_item(OP_PUT, code, COORD_W'($urandom), COORD_W'($urandom),
                FONT_AW'($urandom), BYTE_W'($urandom));
   endtask

   task automatic goto_cursor(input logic [COORD_W-1:0] col, input logic [COORD_W-1:0] row);
      send_item(OP_GOTO, CODE_W'($urandom), col, row, FONT_AW'($urandom), BYTE_W'($urandom));
   endtask

   task automatic load_font(input int addr, input logic [BYTE_W-1:0] fbyte);
      send_item(OP_LOAD, CODE_W'($urandom), COORD_W'($urandom), COORD_W'($urandom),
                FONT_AW'(addr), fbyte);
   endtask

   task automatic load_glyph(input int code);
      for (int i = 0; i < GLYPH_COLS; i++)
         load_font(code * GLYPH_COLS + i, BYTE_W'($urandom));
   endtask

   // hold the request side off until every predicted byte has come out
   task automatic drain_results();
      req_valid <= 1'b0;
      do @(negedge clock); while (expected_bytes.size() != 0);
   endtask

   always @(negedge clock) begin
      if (steady) rsp_ready <= 1'b1;
      else rsp_ready <= ($urandom_range(99) >= 35);
   end

   // ------------------------------------------------------------- checking

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("%0t: mismatch on %s: got %0h, want %0h", $realtime, what, got, want);
      fail_count++;
   endtask

   always @(posedge clock) begin
      lcd_byte_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_bytes.size() == 0) begin
            report_mismatch("transfer with nothing expected", int'(rsp_out_byte), 0);
         end else begin
            want = expected_bytes.pop_front();
            if (rsp_is_data !== want.is_data)
               report_mismatch("is_data", int'(rsp_is_data), int'(want.is_data));
            if (rsp_out_byte !== want.out_byte)
               report_mismatch("out_byte", int'(rsp_out_byte), int'(want.out_byte));
            if (rsp_last !== want.last)
               report_mismatch("last", int'(rsp_last), int'(want.last));
         end
      end
   end

   // ---------------------------------------------------------------- tests

   task automatic test_font_load();
      load_glyph(8'h00);
      load_glyph(8'hff);
      // addresses past the font store are dropped
      load_font(FONT_DEPTH, 8'hff);
      load_font(2047, 8'h00);
   endtask

   task automatic test_unused_op();
      send_item(OP_UNUSED, 8'hff, 8'hff, 8'hff, 11'h7ff, 8'hff);
   endtask

   task automatic test_goto_clamp();
      goto_cursor(8'hff, 8'hff);
      goto_cursor(COORD_W'(CHARS_PER_LINE), COORD_W'(TEXT_LINES));
      goto_cursor(COORD_W'(CHARS_PER_LINE - 1), COORD_W'(TEXT_LINES - 1));
   endtask

   task automatic test_print_wrap();
      goto_cursor(COORD_W'(CHARS_PER_LINE - 1), COORD_W'(TEXT_LINES - 1));
      put_char(8'hff);
      // line is full: wraps from the last line to line 0
      put_char(8'h00);
      put_char(CODE_NEWLINE);
      put_char(CODE_RETURN);
      goto_cursor(8'd2, COORD_W'(TEXT_LINES - 1));
      put_char(CODE_NEWLINE);
      drain_results();
   endtask

   task automatic test_random_traffic(input int count);
      int stop_at;
      int roll;
      stop_at = items_sent + count;
      while (items_sent < stop_at) begin
         roll = $urandom_range(99);
         if (roll < 45 && printable_codes.size() != 0)
            put_char(CODE_W'(printable_codes[$urandom_range(printable_codes.size() - 1)]));
         else if (roll < 53)
            put_char(CODE_NEWLINE);
         else if (roll < 58)
            put_char(CODE_RETURN);
         else if (roll < 75) begin
            if ($urandom_range(9) < 7)
               goto_cursor(COORD_W'($urandom_range(CHARS_PER_LINE - 1, CHARS_PER_LINE - 5)),
                           COORD_W'($urandom_range(TEXT_LINES - 1)));
            else
               goto_cursor(COORD_W'($urandom), COORD_W'($urandom));
         end else if (roll < 85)
            load_glyph($urandom_range(255));
         else if (roll < 92)
            load_font($urandom_range(2047), BYTE_W'($urandom));
         else if (roll < 96)
            send_item(OP_UNUSED, CODE_W'($urandom), COORD_W'($urandom), COORD_W'($urandom),
                      FONT_AW'($urandom), BYTE_W'($urandom));
         else
            drain_results();
      end
   endtask

   task automatic test_steady_stream();
      steady = 1'b1;
      goto_cursor(COORD_W'(CHARS_PER_LINE - 4), COORD_W'($urandom_range(TEXT_LINES - 1)));
      for (int i = 0; i < 36; i++)
         put_char(CODE_W'(printable_codes[$urandom_range(printable_codes.size() - 1)]));
      put_char(CODE_NEWLINE);
      steady = 1'b0;
   endtask

   initial begin
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_op        = OP_PUT;
      req_char_code = '0;
      req_goto_col  = '0;
      req_goto_row  = '0;
      req_font_addr = '0;
      req_font_byte = '0;
      line_cur      = '0;
      char_cur      = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_font_load();
      test_unused_op();
      test_goto_clamp();
      test_print_wrap();
      test_random_traffic(85);
      test_steady_stream();

      drain_results();
      repeat (20) @(negedge clock);
      if (fail_count == 0 && expected_bytes.size() == 0)
         $display("text_cursor_to_lcd_stream regression: pass");
      else
         $display("text_cursor_to_lcd_stream regression: fail");
      $finish;
   end

endmodule
